// File: hdl/gvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants for the grouped value variation checker.
// ----------------------------------------------------------------------------
package gvc_pkg;

    // Field widths fixed by the transaction format
    localparam int REQ_W      = 2;
    localparam int KEY_W      = 64;
    localparam int GID_W      = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RESTART = 2'd2
    } t_req_type;

    // Group status codes
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VARY  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_MODE = 1'b1;

endpackage

// File: hdl/gvc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc request / response interfaces
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface gvc_req_if;
    logic                          valid;
    logic                          ready;
    logic [gvc_pkg::REQ_W-1:0]     req_type;
    logic [gvc_pkg::KEY_W-1:0]     sample_value;
    logic                          sample_missing;
    logic [gvc_pkg::GID_W-1:0]     group_id;

    modport source (output valid, req_type, sample_value, sample_missing, group_id,
                    input ready);
    modport sink   (input valid, req_type, sample_value, sample_missing, group_id,
                    output ready);
endinterface

interface gvc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          any_varying;
    logic [gvc_pkg::STATUS_W-1:0]  group_status;
    logic                          id_error;

    modport source (output valid, any_varying, group_status, id_error, input ready);
    modport sink   (input valid, any_varying, group_status, id_error, output ready);
endinterface

// File: hdl/grouped_value_variation_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_value_variation_check
// Tracks per-group first value and varying status in one state memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries request transactions: a sample (value key, missing flag,
//   group id), a status query for one group, or a restart that clears every
//   group. o_rsp returns exactly one response transaction per request: the
//   sticky any_varying flag, the addressed group's status and id_error.
//   Config writes (i_cfg_we/i_cfg_idx/i_cfg_wdata) set group_count (0 means
//   a single ungrouped set) and answer_mode, which affects no response.
//   Write config only while the block is idle.
// Timing:
//   A request enters the compare stage with its registered memory read, and
//   its response is registered in the output register. One request per
//   cycle is sustained while o_rsp is not stalled and no clearing pass runs,
//   also for back-to-back samples to one group, by a write-to-read forward.
// Reset and restart:
//   The state memory has no per-entry reset. After reset, and after each
//   accepted restart, a clearing pass writes all MAX_GROUPS entries, one per
//   cycle; i_req.ready is low while the pass runs.
// Backpressure:
//   The response sits in an output register; while it waits, one further
//   request can be accepted and held in the compare stage.
// ----------------------------------------------------------------------------
module grouped_value_variation_check #(
    parameter int MAX_GROUPS = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gvc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gvc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    gvc_req_if.sink                            i_req,
    gvc_rsp_if.source                          o_rsp
);

    localparam int AW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int WORD  = VALUE_BITS + 2;   // {varying, seen, first value}
    localparam int SEEN  = VALUE_BITS;
    localparam int VARY  = VALUE_BITS + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_GROUPS - 1);

    // Config
    logic [gvc_pkg::GID_W-1:0] r_group_count;

    // State memory
    logic [WORD-1:0] mem [MAX_GROUPS];
    logic [WORD-1:0] r_rd_data;

    // Clearing pass
    logic            r_clr_active;
    logic [AW-1:0]   r_clr_addr;

    // Compare stage
    logic                        r_s1_valid;
    logic [gvc_pkg::REQ_W-1:0]   r_s1_req;
    logic [VALUE_BITS-1:0]       r_s1_value;
    logic                        r_s1_missing;
    logic                        r_s1_bad;
    logic [AW-1:0]               r_s1_slot;
    logic                        r_s1_fwd;
    logic [WORD-1:0]             r_fwd_data;

    // Sticky flag
    logic r_any;
    logic n_any;

    // Output register
    logic                            r_out_valid;
    logic                            r_out_any;
    logic [gvc_pkg::STATUS_W-1:0]    r_out_status;
    logic                            r_out_err;

    // Handshake
    logic w_s1_adv;
    logic w_in_ready;
    logic w_accept;

    // Front-end decode
    logic                        w_in_bad;
    logic [AW-1:0]               w_in_slot;
    logic [gvc_pkg::GID_W-1:0]   w_gid_m1;

    // Compare stage results
    logic [WORD-1:0]                 w_cur;
    logic                            w_s1_we;
    logic [WORD-1:0]                 w_s1_wdata;
    logic [gvc_pkg::STATUS_W-1:0]    w_status;
    logic                            w_err;

    // Memory write port
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_waddr;
    logic [WORD-1:0] w_mem_wdata;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign w_in_ready = !r_clr_active && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;

    // Config writes; answer_mode is accepted but changes no response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gvc_pkg::CFG_GROUP_COUNT: r_group_count <= i_cfg_wdata;
                gvc_pkg::CFG_ANSWER_MODE: ;
                default: ;
            endcase
        end
    end

    // Group id to slot; group_count zero maps everything to slot 0
    assign w_gid_m1 = i_req.group_id - 1'b1;

    always_comb begin
        w_in_bad  = 1'b0;
        w_in_slot = '0;
        if (r_group_count != '0) begin
            if (i_req.group_id == '0 || i_req.group_id > r_group_count ||
                32'(i_req.group_id) > 32'(MAX_GROUPS)) begin
                w_in_bad = 1'b1;
            end else begin
                w_in_slot = AW'(w_gid_m1);
            end
        end
    end

    // Compare stage: read-modify-write of one group entry
    assign w_cur = r_s1_fwd ? r_fwd_data : r_rd_data;

    always_comb begin
        n_any      = r_any;
        w_s1_we    = 1'b0;
        w_s1_wdata = w_cur;
        w_status   = gvc_pkg::ST_NONE;
        w_err      = 1'b0;
        unique case (r_s1_req)
            gvc_pkg::REQ_SAMPLE, gvc_pkg::REQ_QUERY: begin
                if (r_s1_bad) begin
                    w_err = 1'b1;
                end else if (r_s1_req == gvc_pkg::REQ_SAMPLE && !r_s1_missing &&
                             !w_cur[SEEN]) begin
                    // first value of the group
                    w_s1_we    = 1'b1;
                    w_s1_wdata = {1'b0, 1'b1, r_s1_value};
                    w_status   = gvc_pkg::ST_CONST;
                end else if (r_s1_req == gvc_pkg::REQ_SAMPLE && !r_s1_missing &&
                             w_cur[VALUE_BITS-1:0] != r_s1_value) begin
                    w_s1_we        = 1'b1;
                    w_s1_wdata[VARY] = 1'b1;
                    n_any          = 1'b1;
                    w_status       = gvc_pkg::ST_VARY;
                end else if (w_cur[SEEN]) begin
                    w_status = w_cur[VARY] ? gvc_pkg::ST_VARY : gvc_pkg::ST_CONST;
                end
            end
            gvc_pkg::REQ_RESTART: begin
                n_any = 1'b0;
            end
            default: ;  // unused code: report flag only
        endcase
    end

    // Memory write port: clearing pass or compare-stage write-back
    always_comb begin
        if (r_clr_active) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_s1_adv && w_s1_we;
            w_mem_waddr = r_s1_slot;
            w_mem_wdata = w_s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_accept) begin
            r_rd_data <= mem[w_in_slot];
        end
    end

    // Clearing pass control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (w_accept && i_req.req_type == gvc_pkg::REQ_RESTART) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Compare stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_any <= n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req     <= i_req.req_type;
            r_s1_value   <= i_req.sample_value[VALUE_BITS-1:0];
            r_s1_missing <= i_req.sample_missing;
            r_s1_bad     <= w_in_bad;
            r_s1_slot    <= w_in_slot;
            // same-entry write this edge: read returns old word, take the new one
            r_s1_fwd     <= w_mem_we && (w_mem_waddr == w_in_slot);
            r_fwd_data   <= w_mem_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_any    <= n_any;
            r_out_status <= w_status;
            r_out_err    <= w_err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.any_varying  = r_out_any;
    assign o_rsp.group_status = r_out_status;
    assign o_rsp.id_error     = r_out_err;

endmodule

// File: hdl/gvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_checker
// Port-level assertions for the grouped value variation checker.
// ----------------------------------------------------------------------------
module gvc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic [gvc_pkg::REQ_W-1:0]         i_req_type,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic                              i_rsp_any,
    input logic [gvc_pkg::STATUS_W-1:0]      i_rsp_status,
    input logic                              i_rsp_err
);

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_any) && $stable(i_rsp_status) &&
            $stable(i_rsp_err))
        else $error("response changed while stalled");

    // Restart starts a clearing pass: no request taken next cycle
    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == gvc_pkg::REQ_RESTART |=>
            !i_req_ready)
        else $error("request accepted during clearing pass");

    // Rejected id reports no status
    a_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_err |-> i_rsp_status == gvc_pkg::ST_NONE)
        else $error("id_error with nonzero status");

    // A varying group implies the sticky flag
    a_vary_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == gvc_pkg::ST_VARY |-> i_rsp_any)
        else $error("varying group without any_varying");

endmodule

bind grouped_value_variation_check gvc_checker u_gvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_any    (o_rsp.any_varying),
    .i_rsp_status (o_rsp.group_status),
    .i_rsp_err    (o_rsp.id_error)
);

// File: dv/grouped_value_variation_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_value_variation_check_tb
// Self-checking bench for the grouped value variation checker.
// A scoreboard class keeps its own copy of the per-group first value, seen
// and varying bits and the sticky flag. It predicts one response per
// accepted request and compares every response field by field. Stimulus
// runs in phases: two directed passes over the edge cases, then random traffic
// under several group_count and answer_mode settings. Both sides idle at
// random, and the response side holds off long enough to back up the request
// side.
// ----------------------------------------------------------------------------
module grouped_value_variation_check_tb;

    localparam int NUM_GROUPS  = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_WAIT  = 8;     // margin for responses still in flight
    localparam int HOLD_CYCLES = 300;   // long response hold-off

    // req_type 3 is not in the package enum; the block must still answer it
    localparam logic [gvc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Idle modes for both sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_WIDE = 1;
    localparam int IDLE_SHORT = 2;

    typedef struct packed {
        logic                         any_varying;
        logic [gvc_pkg::STATUS_W-1:0] group_status;
        logic                         id_error;
    } t_status_rsp;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the group state and checks responses in order
    // ------------------------------------------------------------------------
    class variation_scoreboard;
        logic [gvc_pkg::KEY_W-1:0] first_value [NUM_GROUPS];
        bit                        seen        [NUM_GROUPS];
        bit                        varying     [NUM_GROUPS];
        bit                        overall_varying;
        logic [gvc_pkg::GID_W-1:0] group_count;
        t_status_rsp               expected_status_q [$];
        int                        errors;
        int               n_samples, n_queries, n_restarts, n_bad_ids, n_vary_hits;

        function new();
            group_count = '0;
            errors      = 0;
            n_samples   = 0;
            n_queries   = 0;
            n_restarts  = 0;
            n_bad_ids   = 0;
            n_vary_hits = 0;
            clear_groups();
        endfunction

        function void clear_groups();
            for (int g = 0; g < NUM_GROUPS; g++) begin
                seen[g]    = 1'b0;
                varying[g] = 1'b0;
            end
            overall_varying = 1'b0;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // Accepted request: update the shadow state, queue the expected response
        function void note_request(logic [gvc_pkg::REQ_W-1:0] rt,
                                   logic [gvc_pkg::KEY_W-1:0] value,
                                   logic missing, logic [gvc_pkg::GID_W-1:0] gid);
            t_status_rsp exp;
            bit          bad;
            int          slot;
            bad  = 1'b0;
            slot = 0;
            exp  = '0;
            if (rt == gvc_pkg::REQ_RESTART) begin
                clear_groups();
                n_restarts++;
            end else if (rt == REQ_UNUSED) begin
                exp.any_varying = overall_varying;
            end else begin
                // ungrouped mode uses slot 0 and ignores the id
                if (group_count != 0) begin
                    if (gid == 0 || gid > group_count || gid > NUM_GROUPS)
                        bad = 1'b1;
                    else
                        slot = int'(gid) - 1;
                end
                if (rt == gvc_pkg::REQ_SAMPLE) n_samples++;
                else n_queries++;
                if (bad) begin
                    n_bad_ids++;
                end else begin
                    if (rt == gvc_pkg::REQ_SAMPLE && !missing) begin
                        if (!seen[slot]) begin
                            seen[slot]        = 1'b1;
                            first_value[slot] = value;
                        end else if (first_value[slot] != value) begin
                            if (!varying[slot]) n_vary_hits++;
                            varying[slot]   = 1'b1;
                            overall_varying = 1'b1;
                        end
                    end
                    exp.group_status = !seen[slot] ? gvc_pkg::ST_NONE :
                                       (varying[slot] ? gvc_pkg::ST_VARY :
                                                        gvc_pkg::ST_CONST);
                end
                exp.any_varying = overall_varying;
                exp.id_error    = bad;
            end
            expected_status_q.push_back(exp);
        endfunction

        function void check_response(t_status_rsp act);
            t_status_rsp exp;
            if (expected_status_q.size() == 0) begin
                $error("unexpected response: any_varying %0d group_status %0d id_error %0d",
                       act.any_varying, act.group_status, act.id_error);
                errors++;
                return;
            end
            exp = expected_status_q.pop_front();
            if (act.any_varying !== exp.any_varying) begin
                $error("any_varying mismatch: expected %0d, actual %0d",
                       exp.any_varying, act.any_varying);
                errors++;
            end
            if (act.group_status !== exp.group_status) begin
                $error("group_status mismatch: expected %0d, actual %0d",
                       exp.group_status, act.group_status);
                errors++;
            end
            if (act.id_error !== exp.id_error) begin
                $error("id_error mismatch: expected %0d, actual %0d",
                       exp.id_error, act.id_error);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [gvc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gvc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    gvc_req_if req_bus ();
    gvc_rsp_if rsp_bus ();

    grouped_value_variation_check #(
        .MAX_GROUPS (NUM_GROUPS),
        .VALUE_BITS (gvc_pkg::KEY_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    variation_scoreboard       board;
    int                        cycle_count;
    int                        rsp_count;
    int                        send_mode;
    int                        rsp_mode;
    bit                        reset_done;
    logic [gvc_pkg::KEY_W-1:0] key_base;

    // Watchdog: covers the slowest legal run several times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_gap(int mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_WIDE:  return $urandom_range(0, MAX_GAP);
            default:    return $urandom_range(0, 3);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Called just after the clock rises; returns on the rising
    // edge at which the transaction is accepted, with valid still high, so
    // requests sent with no idle gap keep the bus busy back to back.
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [gvc_pkg::REQ_W-1:0] rt,
                            input logic [gvc_pkg::KEY_W-1:0] value,
                            input logic missing,
                            input logic [gvc_pkg::GID_W-1:0] gid);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.req_type       <= rt;
        req_bus.sample_value   <= value;
        req_bus.sample_missing <= missing;
        req_bus.group_id       <= gid;
        do @(posedge i_clk); while (!req_bus.ready);
        board.note_request(rt, value, missing, gid);
    endtask

    // Let everything in flight come back, including any clearing pass
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [gvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gvc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == gvc_pkg::CFG_GROUP_COUNT) board.group_count = data;
    endtask

    // Mostly well-formed ids with repeats on a few hot groups; some bad ids
    function automatic logic [gvc_pkg::GID_W-1:0] pick_gid();
        int gc;
        int r;
        gc = int'(board.group_count);
        if (gc == 0) return gvc_pkg::GID_W'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 9)  return gvc_pkg::GID_W'(gc + 1);
        if (r < 14) return gvc_pkg::GID_W'($urandom_range(gc + 1, 2047));
        if (r < 40) return gvc_pkg::GID_W'($urandom_range(1, gc));
        return gvc_pkg::GID_W'($urandom_range(1, (gc < 8) ? gc : 8));
    endfunction

    // A steady key per group, with occasional random keys that make it vary
    function automatic logic [gvc_pkg::KEY_W-1:0] pick_value(
            logic [gvc_pkg::GID_W-1:0] gid);
        if ($urandom_range(0, 99) < 12) return {$urandom, $urandom};
        return key_base + gvc_pkg::KEY_W'(gid);
    endfunction

    task automatic run_random(input int count);
        logic [gvc_pkg::REQ_W-1:0] rt;
        logic [gvc_pkg::GID_W-1:0] gid;
        int                        r;
        key_base = {$urandom, $urandom};
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) send_mode = $urandom_range(IDLE_NONE, IDLE_SHORT);
            r = $urandom_range(0, 199);
            if (r < 2)       rt = gvc_pkg::REQ_RESTART;
            else if (r < 6)  rt = REQ_UNUSED;
            else if (r < 28) rt = gvc_pkg::REQ_QUERY;
            else             rt = gvc_pkg::REQ_SAMPLE;
            gid = pick_gid();
            send_req(rt, pick_value(gid), ($urandom_range(0, 9) == 0), gid);
        end
    endtask

    task automatic run_phase(input logic [gvc_pkg::CFG_DATA_W-1:0] gc, input logic mode,
                             input int count);
        wait_idle();
        write_cfg(gvc_pkg::CFG_GROUP_COUNT, gc);
        write_cfg(gvc_pkg::CFG_ANSWER_MODE, gvc_pkg::CFG_DATA_W'(mode));
        // the host normally restarts after a count change, but not always
        if ($urandom_range(0, 2) != 0) send_req(gvc_pkg::REQ_RESTART, '0, 1'b0, '0);
        run_random(count);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stalls, plus long hold-offs that back up the block
    // ------------------------------------------------------------------------
    initial begin
        t_status_rsp act;
        int          stall;
        rsp_bus.ready <= 1'b0;
        rsp_count = 0;
        rsp_mode  = IDLE_WIDE;
        wait (reset_done);
        forever begin
            if (rsp_count % 50 == 0) rsp_mode = $urandom_range(IDLE_NONE, IDLE_SHORT);
            if (rsp_count == 400 || rsp_count == 1300) stall = HOLD_CYCLES;
            else stall = draw_gap(rsp_mode);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            act.any_varying  = rsp_bus.any_varying;
            act.group_status = rsp_bus.group_status;
            act.id_error     = rsp_bus.id_error;
            board.check_response(act);
            rsp_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board       = new();
        cycle_count = 0;
        reset_done  = 1'b0;
        send_mode   = IDLE_SHORT;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        req_bus.valid          <= 1'b0;
        req_bus.req_type       <= gvc_pkg::REQ_SAMPLE;
        req_bus.sample_value   <= '0;
        req_bus.sample_missing <= 1'b0;
        req_bus.group_id       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);

        // Directed, ungrouped: id ignored, missing skipped, unused kind, restart
        wait_idle();
        write_cfg(gvc_pkg::CFG_GROUP_COUNT, '0);
        write_cfg(gvc_pkg::CFG_ANSWER_MODE, gvc_pkg::CFG_DATA_W'(1));
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b0, '0);
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b0, 11'd2047);
        send_req(gvc_pkg::REQ_SAMPLE,  '1, 1'b1, 11'd3);
        send_req(gvc_pkg::REQ_QUERY,   '1, 1'b0, 11'd5);
        send_req(gvc_pkg::REQ_SAMPLE,  '1, 1'b0, 11'd1);
        send_req(REQ_UNUSED,           '1, 1'b1, '1);
        send_req(gvc_pkg::REQ_RESTART, '1, 1'b1, '1);
        send_req(gvc_pkg::REQ_QUERY,   '0, 1'b0, '0);

        // Directed, full group range: edge ids, bad ids, equal and differing keys
        wait_idle();
        write_cfg(gvc_pkg::CFG_GROUP_COUNT, gvc_pkg::CFG_DATA_W'(NUM_GROUPS));
        write_cfg(gvc_pkg::CFG_ANSWER_MODE, '0);
        send_req(gvc_pkg::REQ_SAMPLE,  '1, 1'b0, 11'd1024);
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b0, 11'd1);
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b0, 11'd0);
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b0, 11'd1025);
        send_req(gvc_pkg::REQ_SAMPLE,  '1, 1'b0, 11'd2047);
        send_req(gvc_pkg::REQ_SAMPLE,  '0, 1'b1, 11'd0);
        send_req(gvc_pkg::REQ_QUERY,   '0, 1'b0, 11'd1025);
        send_req(gvc_pkg::REQ_SAMPLE,  64'd1, 1'b0, 11'd1);
        send_req(gvc_pkg::REQ_QUERY,   '0, 1'b0, 11'd1024);
        send_req(gvc_pkg::REQ_SAMPLE,  64'd5, 1'b1, 11'd1024);
        send_req(gvc_pkg::REQ_SAMPLE,  '1, 1'b0, 11'd1024);
        send_req(gvc_pkg::REQ_QUERY,   '0, 1'b0, 11'd2);
        send_req(REQ_UNUSED,           '0, 1'b0, 11'd1);
        send_req(gvc_pkg::REQ_RESTART, '0, 1'b0, '0);
        send_req(gvc_pkg::REQ_QUERY,   '0, 1'b0, 11'd1);

        // Random phases across group counts, extremes included
        run_phase('0,                                     1'b1, 270);
        run_phase(gvc_pkg::CFG_DATA_W'(1),                1'b0, 270);
        run_phase(gvc_pkg::CFG_DATA_W'(NUM_GROUPS),       1'b1, 270);
        run_phase(gvc_pkg::CFG_DATA_W'(7),                1'b0, 270);
        run_phase(gvc_pkg::CFG_DATA_W'($urandom_range(2, 64)), 1'b1, 270);
        run_phase(gvc_pkg::CFG_DATA_W'(NUM_GROUPS-1),     1'b0, 270);
        run_phase(gvc_pkg::CFG_DATA_W'(3),                1'b1, 280);

        // Drain, then give late or extra responses a chance to show up
        req_bus.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d samples, %0d queries, %0d restarts, %0d bad ids,",
                 board.n_samples, board.n_queries, board.n_restarts, board.n_bad_ids);
        $display("and %0d groups turned varying; %0d responses checked.",
                 board.n_vary_hits, rsp_count);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
